// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SVMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/svmd_pkg.sv -----
// ---------------------------------------------------------------------------
// svmd_pkg
// types, action codes and glyph tables of the seven-segment meter display
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package svmd_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int GLYPH_COUNT = 28;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_VOLT = 3'd1;
	localparam logic [2:0] ACT_VSET = 3'd2;
	localparam logic [2:0] ACT_CURR = 3'd3;
	localparam logic [2:0] ACT_MODE = 3'd4;

	localparam logic [15:0] CURR_MAX  = 16'd999;
	localparam logic [15:0] LONG_MIN  = 16'd1000;
	localparam logic [4:0]  POINT_OFS = 5'd10;

	typedef logic [4:0] glyph_t;
	typedef logic [2:0] scan_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [12:0] tens;
		logic [3:0]  units;
		logic        long_fmt;
		logic [2:0]  mode;
		logic        mode_ok;
	} prep_t;

	typedef struct packed {
		logic   wr_front;
		logic   wr_back;
		glyph_t g0;
		glyph_t g1;
		glyph_t g2;
	} upd_t;

	// exact value / 10 for any 16-bit value
	function automatic logic [12:0] div10(input logic [15:0] x);
		logic [31:0] p;
		p = {16'd0, x} * 32'd52429;
		return p[31:19];
	endfunction

	function automatic logic [7:0] glyph_seg(input glyph_t g);
		logic [7:0] s;
		case (g)
			5'd0:    s = 8'h3f;
			5'd1:    s = 8'h06;
			5'd2:    s = 8'h5b;
			5'd3:    s = 8'h4f;
			5'd4:    s = 8'h66;
			5'd5:    s = 8'h6d;
			5'd6:    s = 8'h7d;
			5'd7:    s = 8'h07;
			5'd8:    s = 8'h7f;
			5'd9:    s = 8'h6f;
			5'd10:   s = 8'hbf;
			5'd11:   s = 8'h86;
			5'd12:   s = 8'hdb;
			5'd13:   s = 8'hcf;
			5'd14:   s = 8'he6;
			5'd15:   s = 8'hed;
			5'd16:   s = 8'hfd;
			5'd17:   s = 8'h87;
			5'd18:   s = 8'hff;
			5'd19:   s = 8'hef;
			5'd20:   s = 8'hf7;
			5'd21:   s = 8'hf1;
			5'd22:   s = 8'h58;
			5'd23:   s = 8'h39;
			5'd24:   s = 8'h1c;
			5'd25:   s = 8'h3e;
			5'd26:   s = 8'hf8;
			5'd27:   s = 8'h40;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// three glyphs of a mode word, first digit in the low bits
	function automatic logic [14:0] mode_word(input logic [2:0] m);
		logic [14:0] w;
		case (m)
			3'd0:    w = {5'd27, 5'd24, 5'd26};
			3'd1:    w = {5'd27, 5'd22, 5'd26};
			3'd2:    w = {5'd15, 5'd25, 5'd23};
			3'd3:    w = {5'd21, 5'd25, 5'd23};
			3'd4:    w = {5'd5, 5'd10, 5'd23};
			3'd5:    w = {5'd5, 5'd11, 5'd23};
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ----- design/seven_segment_meter_display.sv -----
// a tick item's result is valid once the item has passed the s1 and s2 registers and then the output register
// throughput: one item per cycle, limited only by the output stall of tick results
// update items give no result and change the glyphs seen by every later tick
// reset: glyphs 1 to 6, scan at digit 0, pipeline and output empty
// ---------------------------------------------------------------------------
// seven_segment_meter_display
// six-digit multiplexed seven-segment meter display driver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seven_segment_meter_display (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // value[15:0]
	input  logic [2:0]  s_tuser,  // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // segments[7:0], digit_enable_n[13:8], zero[15:14]
);

	logic            valid_s1;
	logic [2:0]      action_s1;
	logic [15:0]     value_s1;
	logic            valid_s2;
	svmd_pkg::prep_t prep_s2;
	svmd_pkg::prep_t prep;
	svmd_pkg::upd_t  upd;
	logic            out_free;
	logic            tick_s2;
	logic            fire_s2;
	logic            ready_s2;
	logic            fire_s1;
	logic            in_fire;
	logic [7:0]      segments;
	logic [5:0]      digit_enable_n;

	assign tick_s2  = prep_s2.action == svmd_pkg::ACT_TICK;
	assign fire_s2  = valid_s2 && (!tick_s2 || out_free);
	assign ready_s2 = !valid_s2 || fire_s2;
	assign fire_s1  = valid_s1 && ready_s2;
	assign s_tready = !valid_s1 || fire_s1;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= fire_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= s_tuser;
			value_s1  <= s_tdata;
		end
		if (fire_s1) begin
			prep_s2 <= prep;
		end
	end

	svmd_prep u_prep (
		.action (action_s1),
		.value  (value_s1),
		.prep   (prep)
	);

	svmd_digits u_digits (
		.prep (prep_s2),
		.upd  (upd)
	);

	svmd_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire_s2),
		.tick           (tick_s2),
		.upd            (upd),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.segments       (segments),
		.digit_enable_n (digit_enable_n),
		.out_free       (out_free)
	);

	assign m_tdata = {2'b00, digit_enable_n, segments};

	`SVMD_ASSERT_NOW(a_one_digit, m_tvalid, $onehot(~m_tdata[13:8]), "digit select not one-hot")
	`SVMD_ASSERT_NEXT(a_s2_hold, valid_s2 && !fire_s2, valid_s2 && $stable(prep_s2), "stalled item lost")
	`SVMD_ASSERT_NEXT(a_tick_out, fire_s2 && tick_s2, m_tvalid, "tick gave no result")

endmodule

// ----- design/svmd_prep.sv -----
// ---------------------------------------------------------------------------
// svmd_prep
// first stage: saturation, divide by ten, voltage rounding, mode decode
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svmd_prep (
	input  logic [2:0]      action,
	input  logic [15:0]     value,
	output svmd_pkg::prep_t prep
);

	logic [15:0] v;
	logic [12:0] q0;
	logic [3:0]  r;
	logic        voltage;
	logic        long_fmt;

	assign voltage = (action == svmd_pkg::ACT_VOLT) || (action == svmd_pkg::ACT_VSET);
	assign v = ((action == svmd_pkg::ACT_CURR) && (value > svmd_pkg::CURR_MAX))
		? svmd_pkg::CURR_MAX : value;
	assign q0 = svmd_pkg::div10(v);
	assign r = 4'(v - 16'(q0) * 16'd10);
	assign long_fmt = voltage && (value >= svmd_pkg::LONG_MIN);

	always_comb begin
		prep.action   = action;
		// round up by ten keeps units, bumps the tens quotient
		prep.tens     = q0 + 13'((long_fmt && (r > 4'd5)) ? 1 : 0);
		prep.units    = r;
		prep.long_fmt = long_fmt;
		prep.mode     = value[2:0];
		prep.mode_ok  = value < 16'd6;
	end

endmodule

// ----- design/svmd_digits.sv -----
// ---------------------------------------------------------------------------
// svmd_digits
// second stage: decimal digits of the tens quotient and glyph word select
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svmd_digits (
	input  svmd_pkg::prep_t prep,
	output svmd_pkg::upd_t  upd
);

	logic [28:0] p2;
	logic [25:0] p3;
	logic [28:0] p4;
	logic [9:0]  q2;
	logic [6:0]  q3;
	logic [3:0]  q4;
	logic [3:0]  d_tens;
	logic [3:0]  d_hund;
	logic [3:0]  d_thou;
	logic [14:0] word_short;
	logic [14:0] word_long;
	logic [14:0] word_mode;

	// reciprocal multiplies, exact for the 13-bit range
	assign p2 = 29'(prep.tens) * 29'd52429;
	assign p3 = 26'(prep.tens) * 26'd5243;
	assign p4 = 29'(prep.tens) * 29'd33555;
	assign q2 = p2[28:19];
	assign q3 = p3[25:19];
	assign q4 = p4[28:25];

	assign d_tens = 4'(prep.tens - 13'(q2) * 13'd10);
	assign d_hund = 4'(q2 - 10'(q3) * 10'd10);
	assign d_thou = 4'(q3 - 7'(q4) * 7'd10);

	assign word_short = {5'(prep.units), 5'(d_tens), 5'(d_hund) + svmd_pkg::POINT_OFS};
	assign word_long  = {5'(d_tens), 5'(d_hund) + svmd_pkg::POINT_OFS, 5'(d_thou)};
	assign word_mode  = svmd_pkg::mode_word(prep.mode);

	always_comb begin
		logic [14:0] w;
		w = word_short;
		upd.wr_front = 1'b0;
		upd.wr_back  = 1'b0;
		case (prep.action)
			svmd_pkg::ACT_VOLT: begin
				upd.wr_front = 1'b1;
				w = prep.long_fmt ? word_long : word_short;
			end
			svmd_pkg::ACT_VSET: begin
				upd.wr_back = 1'b1;
				w = prep.long_fmt ? word_long : word_short;
			end
			svmd_pkg::ACT_CURR: begin
				upd.wr_back = 1'b1;
			end
			svmd_pkg::ACT_MODE: begin
				upd.wr_front = prep.mode_ok;
				w = word_mode;
			end
			default: begin
				w = word_short;
			end
		endcase
		upd.g0 = w[4:0];
		upd.g1 = w[9:5];
		upd.g2 = w[14:10];
	end

endmodule

// ----- design/svmd_scan.sv -----
// ---------------------------------------------------------------------------
// svmd_scan
// glyph store, digit scan and the registered segment output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module svmd_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           tick,
	input  svmd_pkg::upd_t upd,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [7:0]     segments,
	output logic [5:0]     digit_enable_n,
	output logic           out_free
);

	svmd_pkg::glyph_t store_q [svmd_pkg::DIGIT_COUNT];
	svmd_pkg::scan_t  scan_q;
	svmd_pkg::scan_t  pos;
	svmd_pkg::scan_t  pos_next;
	logic             out_valid_q;
	logic [7:0]       seg_q;
	logic [5:0]       en_n_q;

	assign pos = (scan_q >= 3'(svmd_pkg::DIGIT_COUNT)) ? 3'd0 : scan_q;
	assign pos_next = (pos == 3'(svmd_pkg::DIGIT_COUNT - 1)) ? 3'd0 : pos + 3'd1;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < svmd_pkg::DIGIT_COUNT; i++) begin
				store_q[i] <= 5'(i + 1);
			end
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && upd.wr_front) begin
				store_q[0] <= upd.g0;
				store_q[1] <= upd.g1;
				store_q[2] <= upd.g2;
			end
			if (fire && upd.wr_back) begin
				store_q[3] <= upd.g0;
				store_q[4] <= upd.g1;
				store_q[5] <= upd.g2;
			end
			if (fire && tick) begin
				scan_q      <= pos_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && tick) begin
			seg_q  <= svmd_pkg::glyph_seg(store_q[pos]);
			en_n_q <= ~(6'd1 << pos);
		end
	end

	assign out_valid      = out_valid_q;
	assign segments       = seg_q;
	assign digit_enable_n = en_n_q;

endmodule
